>>> rtl/ihd_pkg.sv
// ----------------------------------------------------------------------------
// ihd_pkg: shared types and constants of the 2x2 half downscaler
// Register indexes, field widths, channel payloads and the line operation
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package ihd_pkg;

   // Defaults and fixed sizes
   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int COMP_COUNT        = 4;
   localparam int QUEUE_DEPTH       = 4;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_COMPONENT_COUNT = CSR_INDEX_W'(2);

   // Register widths and reset values
   localparam int WIDTH_W  = 13;
   localparam int HEIGHT_W = 16;
   localparam int COUNT_W  = 3;
   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1);
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(4);

   typedef logic [COMP_COUNT-1:0][7:0] pixel_type;
   typedef logic [COMP_COUNT-1:0][8:0] pair_word_type;

   typedef struct packed {
      logic [7:0] comp0;
      logic [7:0] comp1;
      logic [7:0] comp2;
      logic [7:0] comp3;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_comp0;
      logic [7:0] out_comp1;
      logic [7:0] out_comp2;
      logic [7:0] out_comp3;
      logic       row_end;
      logic       image_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_payload_type;

   // One horizontal pair: either stored in the line or combined into an output
   typedef struct packed {
      logic                  write_line;
      logic                  use_line;
      logic [COMP_COUNT-1:0] comp_en;
      logic                  row_end;
      logic                  image_end;
      pair_word_type         pair;
   } line_op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> rtl/ihd_stream_if.sv
// ----------------------------------------------------------------------------
// ihd_stream_if: valid/ready channel
// Carries one payload per transaction; the payload type is set per instance.
// ----------------------------------------------------------------------------
interface ihd_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/ihd_ram.sv
// ----------------------------------------------------------------------------
// ihd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ihd_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 2048,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ihd_front.sv
// ----------------------------------------------------------------------------
// ihd_front: pixel intake and classification
// Holds the configuration, tracks the raster position, pairs pixels
// horizontally and issues one line operation for each finished pair.
// ----------------------------------------------------------------------------
module ihd_front #(
   parameter int MAX_WIDTH = 4096,
   parameter int ADDR_W    = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   ihd_stream_if.sink                req_ch,
   ihd_stream_if.sink                csr_ch,
   input  ihd_pkg::queue_status_type q_status,
   output logic                      push,
   output ihd_pkg::line_op_type      push_op,
   output logic [ADDR_W-1:0]         push_slot
);
   import ihd_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EW    = $clog2(MAX_WIDTH + 1);

   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [HEIGHT_W-1:0] height_ff, height_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   pixel_type           held_ff;

   logic                  accept;
   logic                  csr_write;
   logic                  restart;
   logic [EW-1:0]         eff_width;
   logic [HEIGHT_W-1:0]   eff_height;
   logic [COUNT_W-1:0]    eff_count;
   logic                  last_col;
   logic                  last_row;
   logic                  have_pair;
   logic [COMP_COUNT-1:0] comp_en;
   pixel_type             in_pix;
   pixel_type             pix;
   pair_word_type         pair;

   assign accept    = req_ch.valid && req_ch.ready;
   assign csr_write = csr_ch.valid && csr_ch.ready;

   assign req_ch.ready = !q_status.full;
   assign csr_ch.ready = 1'b1;

   // Decode register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      count_in  = count_ff;
      restart   = 1'b0;
      if (csr_write) begin
         unique case (csr_ch.payload.index)
            REG_IMAGE_WIDTH: begin
               width_in = csr_ch.payload.data[WIDTH_W-1:0];
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_ch.payload.data[HEIGHT_W-1:0];
               restart   = 1'b1;
            end
            REG_COMPONENT_COUNT: begin
               count_in = csr_ch.payload.data[COUNT_W-1:0];
               restart  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp register values into their working ranges
   always_comb begin
      if (width_ff == '0) begin
         eff_width = EW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = EW'(width_ff);
      end
      eff_height = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      if (count_ff == '0) begin
         eff_count = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(COMP_COUNT)) begin
         eff_count = COUNT_W'(COMP_COUNT);
      end else begin
         eff_count = count_ff;
      end
   end

   assign last_col = (EW'(col_ff) + EW'(1)) >= eff_width;
   assign last_row = ((HEIGHT_W + 1)'(row_ff) + (HEIGHT_W + 1)'(1))
                     >= (HEIGHT_W + 1)'(eff_height);

   assign in_pix = {req_ch.payload.comp3, req_ch.payload.comp2,
                    req_ch.payload.comp1, req_ch.payload.comp0};

   // Mask unused components and form the horizontal pair sum
   always_comb begin
      for (int c = 0; c < COMP_COUNT; c++) begin
         comp_en[c] = COUNT_W'(c) < eff_count;
         pix[c]     = comp_en[c] ? in_pix[c] : 8'd0;
         pair[c]    = col_ff[0] ? (9'(held_ff[c]) + 9'(pix[c])) : {pix[c], 1'b0};
      end
   end

   assign have_pair = col_ff[0] || last_col;

   // Build the line operation
   always_comb begin
      push_op.write_line = !row_ff[0] && !last_row;
      push_op.use_line   = row_ff[0];
      push_op.comp_en    = comp_en;
      push_op.row_end    = last_col;
      push_op.image_end  = last_col && last_row;
      push_op.pair       = pair;
   end

   assign push      = accept && have_pair;
   assign push_slot = ADDR_W'(col_ff >> 1);

   // Advance the raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + HEIGHT_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         count_ff  <= COUNT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         count_ff  <= count_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // Hold the even-column pixel for its partner
   always_ff @(posedge clock) begin
      if (accept && !col_ff[0] && !last_col) begin
         held_ff <= pix;
      end
   end

endmodule

>>> rtl/ihd_queue.sv
// ----------------------------------------------------------------------------
// ihd_queue: line operation queue
// Short register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module ihd_queue #(
   parameter int ADDR_W = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ihd_pkg::line_op_type      push_op,
   input  logic [ADDR_W-1:0]         push_slot,
   input  logic                      pop,
   output ihd_pkg::line_op_type      head_op,
   output logic [ADDR_W-1:0]         head_slot,
   output ihd_pkg::queue_status_type q_status
);
   import ihd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   line_op_type       op_ff   [QUEUE_DEPTH];
   logic [ADDR_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign q_status.full  = count_ff == CNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;

   assign head_op   = op_ff[rd_ptr_ff];
   assign head_slot = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= push_op;
         slot_ff[wr_ptr_ff] <= push_slot;
      end
   end

   // Never write into a full queue unless an entry leaves in the same cycle, or read from an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_status.full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue pop while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a push");

endmodule

>>> rtl/ihd_back.sv
// ----------------------------------------------------------------------------
// ihd_back: line store and averaging
// Writes even-row pair sums into the line RAM, reads them back for odd rows,
// forms the rounded 2x2 mean and drives the result register.
// ----------------------------------------------------------------------------
module ihd_back #(
   parameter int ADDR_W     = 11,
   parameter int LINE_DEPTH = 2048
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ihd_pkg::queue_status_type q_status,
   input  ihd_pkg::line_op_type      head_op,
   input  logic [ADDR_W-1:0]         head_slot,
   output logic                      pop,
   ihd_stream_if.source              rsp_ch
);
   import ihd_pkg::*;

   localparam int WORD_W = $bits(pair_word_type);

   logic            s1_valid_ff, s1_valid_in;
   line_op_type     s1_op_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic               out_free;
   logic               s1_free;
   logic               wr_en;
   logic               rd_en;
   logic [WORD_W-1:0]  rd_word;
   pair_word_type      other;
   pixel_type          mean;
   logic [10:0]        sum;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = !q_status.empty && s1_free;
   assign wr_en    = pop && head_op.write_line;
   assign rd_en    = pop && !head_op.write_line;

   ihd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_slot),
      .wr_data (head_op.pair),
      .rd_en   (rd_en),
      .rd_addr (head_slot),
      .rd_data (rd_word)
   );

   // Combine the stored or repeated pair with the current pair
   always_comb begin
      other = s1_op_ff.use_line ? pair_word_type'(rd_word) : s1_op_ff.pair;
      sum   = '0;
      for (int c = 0; c < COMP_COUNT; c++) begin
         sum     = 11'(other[c]) + 11'(s1_op_ff.pair[c]) + 11'd2;
         mean[c] = s1_op_ff.comp_en[c] ? sum[9:2] : 8'd0;
      end
   end

   always_comb begin
      rsp_data_in.out_comp0 = mean[0];
      rsp_data_in.out_comp1 = mean[1];
      rsp_data_in.out_comp2 = mean[2];
      rsp_data_in.out_comp3 = mean[3];
      rsp_data_in.row_end   = s1_op_ff.row_end;
      rsp_data_in.image_end = s1_op_ff.image_end;
   end

   // Move operations through the read stage and the result register
   always_comb begin
      if (rd_en) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_valid_ff && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_op_ff <= head_op;
      end
      if (s1_valid_ff && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // A stalled read stage takes nothing from the queue
   a_stall_no_pop: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !pop)
      else $error("queue popped while read stage stalled");

   // Every line read lands in the read stage
   a_read_fills_stage: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> s1_valid_ff)
      else $error("line read lost");

   // Hold a refused result unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid && $stable(rsp_ch.payload)))
      else $error("result changed while stalled");

endmodule

>>> rtl/image_half_downscale_2x2.sv
// ----------------------------------------------------------------------------
// image_half_downscale_2x2: 2x2 box filter downscaler
// Halves a raster image in both directions with rounded 2x2 means.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  takes one pixel (comp0..comp3) per transaction in raster order,
//           one pixel per clock while the internal queue has room.
//   rsp_ch  gives one output pixel per 2x2 block; row_end marks the last pixel
//           of an output row and image_end the last pixel of the image.
//   csr_ch  writes image_width (0), image_height (1) or component_count (2);
//           always ready. A write restarts the image at its first pixel; the
//           user writes only while the block is idle; it is not enforced.
//   Timing: a result passes the queue, the line RAM read stage and the result
//   register after the pixel completing it is accepted. Sustained rate is one
//   pixel per clock while the receiver takes results; results come at most one
//   per clock, set by the single line RAM port pair and the result register.
//   Reset: registers return to width 1, height 1, four components, and the
//   position goes to the first pixel. The line RAM needs no clearing.
//   Receiver stall: the result register holds; a four-entry operation queue
//   absorbs pairs until it fills, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module image_half_downscale_2x2 #(
   parameter int MAX_WIDTH = ihd_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ihd_stream_if.sink    req_ch,
   ihd_stream_if.source  rsp_ch,
   ihd_stream_if.sink    csr_ch
);
   import ihd_pkg::*;

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   queue_status_type  q_status;
   logic              push;
   line_op_type       push_op;
   logic [ADDR_W-1:0] push_slot;
   logic              pop;
   line_op_type       head_op;
   logic [ADDR_W-1:0] head_slot;

   ihd_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .q_status  (q_status),
      .push      (push),
      .push_op   (push_op),
      .push_slot (push_slot)
   );

   ihd_queue #(
      .ADDR_W (ADDR_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .push_slot (push_slot),
      .pop       (pop),
      .head_op   (head_op),
      .head_slot (head_slot),
      .q_status  (q_status)
   );

   ihd_back #(
      .ADDR_W     (ADDR_W),
      .LINE_DEPTH (LINE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_op   (head_op),
      .head_slot (head_slot),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
